// File: rtl/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude core.
// No dependencies; used by the top level by scoped names.
`default_nettype none

package sgm_pkg;

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_BITS = 11;
   localparam int MAG_BITS      = 11;
   localparam int COORD_BITS    = 10;
   localparam int INPUT_BITS    = 8;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MIN_DIM       = 3;

   localparam logic [CSR_DATA_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [CSR_DATA_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;

   // Position and flags that travel with an item down the pipeline
   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic                  last;
      logic                  emit;
   } side_type;

endpackage

`default_nettype wire

// File: rtl/sobel_gradient_magnitude_core.sv
// Channel   Dir  Handshake        Payload
// req       in   valid/ready      pixel_value[7:0], raster order
// rsp       out  valid/ready      magnitude[10:0], out_row, out_col, frame_last
// csr       in   write enable     index (0 width, 1 height), wr_data[10:0]
//
// One pixel per cycle sustained while req_ready is high;
// the root pipeline takes two result bits a stage.
// The line stores share one RAM, read at accept and written back in the next cycle.
// Reset (synchronous) clears counters, window and queue; line stores are not cleared.
// A result queue sized to the pipeline keeps req_ready high while rsp stalls
// until queue plus in-flight items reach its depth.
// Depends on sgm_pkg and sgm_ram.
`default_nettype none

module sobel_gradient_magnitude_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // pixel input
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [sgm_pkg::INPUT_BITS-1:0]        req_pixel_value,
   // gradient output
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [sgm_pkg::MAG_BITS-1:0]          rsp_magnitude,
   output logic      [sgm_pkg::COORD_BITS-1:0]        rsp_out_row,
   output logic      [sgm_pkg::COORD_BITS-1:0]        rsp_out_col,
   output logic                                       rsp_frame_last,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic                                  csr_index,
   input  wire logic [sgm_pkg::CSR_DATA_BITS-1:0]     csr_wr_data
);

   localparam int PW    = (PIXEL_BITS < sgm_pkg::INPUT_BITS) ? PIXEL_BITS
                                                             : sgm_pkg::INPUT_BITS;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int LW0   = $clog2(MAX_WIDTH + 1);
   localparam int LW    = (LW0 > sgm_pkg::CSR_DATA_BITS) ? LW0 : sgm_pkg::CSR_DATA_BITS;
   localparam int HW    = sgm_pkg::CSR_DATA_BITS;
   localparam int GW    = PW + 4;                // signed Sobel sum
   localparam int AB    = PW + 2;                // absolute value
   localparam int SQW   = 2 * AB;                // one square
   localparam int RB    = PW + 3;                // root bits
   localparam int NS    = (RB + 1) / 2;          // root stages, two bits each
   localparam int STEPS = 2 * NS;
   localparam int RW    = 2 * STEPS;             // radicand
   localparam int PIPE_DEPTH = 4 + NS;
   localparam int FIFO_DEPTH = 1 << $clog2(PIPE_DEPTH + 2);
   localparam int FP    = $clog2(FIFO_DEPTH);
   localparam int CRW   = $clog2(FIFO_DEPTH + 1);

   // ---------------------------------------------------------------- config
   logic [HW-1:0] frame_width_ff, frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sgm_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= sgm_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (sgm_pkg::csr_index_type'(csr_index))
            sgm_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wr_data;
            sgm_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- raster count
   logic                       accept;
   logic [CW-1:0]              col_ff, col_in;
   logic [sgm_pkg::COORD_BITS-1:0] row_ff, row_in;
   logic [LW-1:0]              w_lim;
   logic [HW-1:0]              h_lim;
   logic                       row_end, frame_end;
   sgm_pkg::side_type          side0;
   logic                       interior0;

   assign accept = req_valid && req_ready;

   always_comb begin
      w_lim = LW'(frame_width_ff);
      if (w_lim < LW'(sgm_pkg::MIN_DIM)) begin
         w_lim = LW'(sgm_pkg::MIN_DIM);
      end else if (w_lim > LW'(MAX_WIDTH)) begin
         w_lim = LW'(MAX_WIDTH);
      end
      h_lim = frame_height_ff;
      if (h_lim < HW'(sgm_pkg::MIN_DIM)) begin
         h_lim = HW'(sgm_pkg::MIN_DIM);
      end else if (h_lim > HW'(sgm_pkg::MAX_HEIGHT)) begin
         h_lim = HW'(sgm_pkg::MAX_HEIGHT);
      end
      row_end   = (LW'(col_ff) + LW'(1)) >= w_lim;
      frame_end = row_end && ((HW'(row_ff) + HW'(1)) >= h_lim);
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
      side0.row  = row_ff - 1'b1;
      side0.col  = sgm_pkg::COORD_BITS'(col_ff - 1'b1);
      side0.last = frame_end;
      side0.emit = (row_ff != '0) && (col_ff != '0);
      interior0  = (row_ff >= 2) && (col_ff >= 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------ line stores
   // upper row in the high half, middle row in the low half
   logic              s1_valid_ff;
   logic [CW-1:0]     s1_col_ff;
   logic [PW-1:0]     s1_px_ff;
   logic              s1_interior_ff;
   sgm_pkg::side_type s1_side_ff;
   logic [2*PW-1:0]   line_rd;
   logic [PW-1:0]     top, mid;

   sgm_ram #(
      .WIDTH (2 * PW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data ({mid, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign top = line_rd[2*PW-1:PW];
   assign mid = line_rd[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_col_ff      <= col_ff;
         s1_px_ff       <= req_pixel_value[PW-1:0];
         s1_interior_ff <= interior0;
         s1_side_ff     <= side0;
      end
   end

   // ------------------------------------------------------- window and sums
   // win_ff[0..2]: oldest column top..bottom, win_ff[3..5]: next column
   logic [PW-1:0]        win_ff [0:5];
   logic signed [GW-1:0] gx, gy;
   logic [AB-1:0]        ax_in, ay_in;

   always_comb begin
      gx = GW'(top) + (GW'(mid) << 1) + GW'(s1_px_ff)
         - GW'(win_ff[0]) - (GW'(win_ff[1]) << 1) - GW'(win_ff[2]);
      gy = GW'(win_ff[2]) + (GW'(win_ff[5]) << 1) + GW'(s1_px_ff)
         - GW'(win_ff[0]) - (GW'(win_ff[3]) << 1) - GW'(top);
      ax_in = gx[GW-1] ? AB'(-gx) : AB'(gx);
      ay_in = gy[GW-1] ? AB'(-gy) : AB'(gy);
      if (!s1_interior_ff) begin
         ax_in = '0;
         ay_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_px_ff;
      end
   end

   // ------------------------------------------------------ squares and sum
   logic              s2_valid_ff, s3_valid_ff;
   sgm_pkg::side_type s2_side_ff, s3_side_ff;
   logic [AB-1:0]     s2_ax_ff, s2_ay_ff;
   logic [SQW-1:0]    s3_sqx_ff, s3_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s2_ax_ff   <= ax_in;
      s2_ay_ff   <= ay_in;
      s2_side_ff <= s1_side_ff;
      s3_sqx_ff  <= SQW'(s2_ax_ff) * SQW'(s2_ax_ff);
      s3_sqy_ff  <= SQW'(s2_ay_ff) * SQW'(s2_ay_ff);
      s3_side_ff <= s2_side_ff;
   end

   // ------------------------------------------------------------- root pipe
   // restoring digit-by-digit square root, two result bits per stage
   logic              sq_valid_ff [0:NS];
   sgm_pkg::side_type sq_side_ff  [0:NS];
   logic [RW-1:0]     sq_rad_ff   [0:NS];
   logic [STEPS+1:0]  sq_rem_ff   [0:NS];
   logic [STEPS-1:0]  sq_root_ff  [0:NS];
   logic [RW-1:0]     sq_rad_in   [1:NS];
   logic [STEPS+1:0]  sq_rem_in   [1:NS];
   logic [STEPS-1:0]  sq_root_in  [1:NS];

   always_comb begin
      logic [RW-1:0]    rad_t;
      logic [STEPS+1:0] rem_t, cand, trial;
      logic [STEPS-1:0] root_t;
      for (int s = 0; s < NS; s++) begin
         rad_t  = sq_rad_ff[s];
         rem_t  = sq_rem_ff[s];
         root_t = sq_root_ff[s];
         for (int k = 0; k < 2; k++) begin
            cand  = {rem_t[STEPS-1:0], rad_t[RW-1 -: 2]};
            trial = {root_t, 2'b01};
            if (cand >= trial) begin
               rem_t  = cand - trial;
               root_t = {root_t[STEPS-2:0], 1'b1};
            end else begin
               rem_t  = cand;
               root_t = {root_t[STEPS-2:0], 1'b0};
            end
            rad_t = rad_t << 2;
         end
         sq_rad_in[s+1]  = rad_t;
         sq_rem_in[s+1]  = rem_t;
         sq_root_in[s+1] = root_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NS; s++) begin
            sq_valid_ff[s] <= 1'b0;
         end
      end else begin
         sq_valid_ff[0] <= s3_valid_ff;
         for (int s = 1; s <= NS; s++) begin
            sq_valid_ff[s] <= sq_valid_ff[s-1];
         end
      end
      sq_rad_ff[0]  <= RW'(s3_sqx_ff) + RW'(s3_sqy_ff);
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
      sq_side_ff[0] <= s3_side_ff;
      for (int s = 1; s <= NS; s++) begin
         sq_rad_ff[s]  <= sq_rad_in[s];
         sq_rem_ff[s]  <= sq_rem_in[s];
         sq_root_ff[s] <= sq_root_in[s];
         sq_side_ff[s] <= sq_side_ff[s-1];
      end
   end

   // ----------------------------------------------------------- result queue
   // credit counts items accepted and not yet gone (dropped or transferred)
   logic                          push, pop, drop;
   logic [FP-1:0]                 wr_ptr_ff, rd_ptr_ff;
   logic [CRW-1:0]                count_ff, credit_ff;
   logic [sgm_pkg::MAG_BITS-1:0]  q_mag_ff  [0:FIFO_DEPTH-1];
   sgm_pkg::side_type             q_side_ff [0:FIFO_DEPTH-1];

   assign push = sq_valid_ff[NS] && sq_side_ff[NS].emit;
   assign drop = sq_valid_ff[NS] && !sq_side_ff[NS].emit;
   assign pop  = rsp_valid && rsp_ready;

   assign req_ready      = credit_ff < CRW'(FIFO_DEPTH);
   assign rsp_valid      = count_ff != '0;
   assign rsp_magnitude  = q_mag_ff[rd_ptr_ff];
   assign rsp_out_row    = q_side_ff[rd_ptr_ff].row;
   assign rsp_out_col    = q_side_ff[rd_ptr_ff].col;
   assign rsp_frame_last = q_side_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff  <= count_ff + CRW'(push) - CRW'(pop);
         credit_ff <= credit_ff + CRW'(accept) - CRW'(drop) - CRW'(pop);
      end
      if (push) begin
         q_mag_ff[wr_ptr_ff]  <= sgm_pkg::MAG_BITS'(sq_root_ff[NS]);
         q_side_ff[wr_ptr_ff] <= sq_side_ff[NS];
      end
   end

`ifndef NO_ASSERTIONS
   // credit never exceeds the queue depth
   assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CRW'(FIFO_DEPTH))
      else $error("credit counter overflow");

   // a finished result always finds room in the queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CRW'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   // queued results never outnumber outstanding credits
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= credit_ff)
      else $error("queue holds more than was accepted");

   // line store write-back never hits the address read in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && accept) |-> (s1_col_ff != col_ff))
      else $error("line store read/write collision");

   // accepting the last pixel of a frame restarts the count at row 0, column 0
   assert property (@(posedge clock) disable iff (reset)
      (accept && frame_end) |=> (row_ff == '0) && (col_ff == '0))
      else $error("raster counters did not wrap at frame end");
`endif

endmodule

`default_nettype wire

// File: rtl/sgm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sgm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for sobel_gradient_magnitude_core: pixel frames in, gradient magnitudes out.
// A built-in Sobel predictor checks every result. Needs sgm_pkg, sgm_ram and the core RTL only.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH = 1024;
   localparam int IDLE_PCT   = 38;
   localparam int DRAIN_WAIT = 32;

   typedef struct packed {
      logic [sgm_pkg::MAG_BITS-1:0]   magnitude;
      logic [sgm_pkg::COORD_BITS-1:0] row;
      logic [sgm_pkg::COORD_BITS-1:0] col;
      logic                           last;
   } gradient_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [sgm_pkg::INPUT_BITS-1:0]    req_pixel_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [sgm_pkg::MAG_BITS-1:0]      rsp_magnitude;
   logic [sgm_pkg::COORD_BITS-1:0]    rsp_out_row;
   logic [sgm_pkg::COORD_BITS-1:0]    rsp_out_col;
   logic                              rsp_frame_last;
   logic                              csr_wr_en = 1'b0;
   logic                              csr_index = 1'b0;
   logic [sgm_pkg::CSR_DATA_BITS-1:0] csr_wr_data = '0;

   // predictor state
   logic [sgm_pkg::CSR_DATA_BITS-1:0] cfg_width  = sgm_pkg::FRAME_WIDTH_RESET;
   logic [sgm_pkg::CSR_DATA_BITS-1:0] cfg_height = sgm_pkg::FRAME_HEIGHT_RESET;
   logic [7:0]               upper_mem  [LINE_DEPTH];
   logic [7:0]               middle_mem [LINE_DEPTH];
   logic [7:0]               win_cols   [6];
   int unsigned              row_pos = 0;
   int unsigned              col_pos = 0;

   logic [7:0]    pixel_q [$];
   gradient_type  gradient_q [$];
   gradient_type  want_grad;
   logic [7:0]    last_px = '0;
   int            outstanding_pixels = 0;
   int            pixels_sent = 0;
   int            gradients_checked = 0;
   int            frames_closed = 0;
   int            geometries_run = 0;
   int            mismatch_count = 0;
   bit            no_idle = 1'b0;

   sobel_gradient_magnitude_core #(
      .MAX_WIDTH  (LINE_DEPTH),
      .PIXEL_BITS (8)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_magnitude   (rsp_magnitude),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_last  (rsp_frame_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [sgm_pkg::CSR_DATA_BITS-1:0] v,
                                             input int unsigned hi);
      if (v < sgm_pkg::MIN_DIM) return sgm_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned eff_width();
      return clamp_dim(cfg_width, LINE_DEPTH);
   endfunction

   function automatic int unsigned eff_height();
      return clamp_dim(cfg_height, sgm_pkg::MAX_HEIGHT);
   endfunction

   function automatic logic [sgm_pkg::MAG_BITS-1:0] floor_root(input int unsigned v);
      logic [sgm_pkg::MAG_BITS-1:0] root;
      int unsigned                  trial;
      int                           b;
      root = '0;
      for (b = sgm_pkg::MAG_BITS - 1; b >= 0; b--) begin
         trial = root | (1 << b);
         if (trial * trial <= v) root[b] = 1'b1;
      end
      return root;
   endfunction

   // Sobel window update for one accepted pixel; queues the gradient it releases
   task automatic predict_pixel(input logic [7:0] px);
      int unsigned   w, h, r, c;
      int            p [9];
      int            gx, gy;
      bit            row_end, frame_end;
      logic [7:0]    top, mid;
      gradient_type  res;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      row_end   = (c + 1 >= w);
      frame_end = row_end && (r + 1 >= h);
      top = upper_mem[c];
      mid = middle_mem[c];
      p[0] = win_cols[0]; p[1] = win_cols[3]; p[2] = top;
      p[3] = win_cols[1]; p[4] = win_cols[4]; p[5] = mid;
      p[6] = win_cols[2]; p[7] = win_cols[5]; p[8] = px;
      if (r >= 1 && c >= 1) begin
         res.magnitude = '0;
         if (r >= 2 && c >= 2) begin
            gx = p[2] - p[0] + 2 * (p[5] - p[3]) + p[8] - p[6];
            gy = p[6] + 2 * p[7] + p[8] - p[0] - 2 * p[1] - p[2];
            res.magnitude = floor_root(gx * gx + gy * gy);
         end
         res.row  = sgm_pkg::COORD_BITS'(r - 1);
         res.col  = sgm_pkg::COORD_BITS'(c - 1);
         res.last = frame_end;
         gradient_q.push_back(res);
      end
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = top;
      win_cols[4] = mid;
      win_cols[5] = px;
      upper_mem[c]  = mid;
      middle_mem[c] = px;
      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : ((r + 1) & 10'h3FF);
      end else begin
         col_pos = (c + 1) & 10'h3FF;
      end
   endtask

   // Pixel source: one transfer per handshake, gaps at random unless no_idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_pixel(req_pixel_value);
            pixels_sent++;
            outstanding_pixels--;
         end
         if (!req_valid || req_ready) begin
            if (pixel_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid       <= 1'b1;
               req_pixel_value <= pixel_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] MISMATCH %s", $realtime, what);
   endtask

   // Gradient sink and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            gradients_checked++;
            if (rsp_frame_last === 1'b1) frames_closed++;
            if (gradient_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected mag=%0d row=%0d col=%0d last=%0b",
                             rsp_magnitude, rsp_out_row, rsp_out_col, rsp_frame_last));
            end else begin
               want_grad = gradient_q.pop_front();
               if (rsp_magnitude !== want_grad.magnitude || rsp_out_row !== want_grad.row ||
                   rsp_out_col !== want_grad.col || rsp_frame_last !== want_grad.last)
                  flag_mismatch($sformatf(
                     "exp mag=%0d row=%0d col=%0d last=%0b got mag=%0d row=%0d col=%0d last=%0b",
                     want_grad.magnitude, want_grad.row, want_grad.col, want_grad.last,
                     rsp_magnitude, rsp_out_row, rsp_out_col, rsp_frame_last));
            end
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic push_pixel(input logic [7:0] v);
      pixel_q.push_back(v);
      outstanding_pixels++;
   endtask

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(3))
         0, 1: last_px = 8'($urandom_range(255));
         2: last_px = $urandom_range(1) ? 8'hFF : 8'h00;
         default: last_px = last_px + 8'($urandom_range(6)) - 8'd3;
      endcase
      return last_px;
   endfunction

   task automatic push_random(input int unsigned n);
      repeat (n) push_pixel(random_pixel());
   endtask

   // Block is idle: every pixel taken, every gradient seen, pipeline flushed
   task automatic settle();
      do @(posedge clock); while (outstanding_pixels != 0 || gradient_q.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input sgm_pkg::csr_index_type idx,
                            input logic [sgm_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == sgm_pkg::CSR_FRAME_WIDTH) cfg_width = data;
      else cfg_height = data;
   endtask

   task automatic set_geometry(input logic [sgm_pkg::CSR_DATA_BITS-1:0] w,
                               input logic [sgm_pkg::CSR_DATA_BITS-1:0] h);
      write_csr(sgm_pkg::CSR_FRAME_WIDTH, w);
      write_csr(sgm_pkg::CSR_FRAME_HEIGHT, h);
      geometries_run++;
   endtask

   // Pixels left until the predictor closes the current frame
   function automatic int unsigned pixels_to_frame_end();
      int unsigned n;
      n = (col_pos + 1 >= eff_width()) ? 1 : eff_width() - col_pos;
      if (row_pos + 1 < eff_height()) n += (eff_height() - 1 - row_pos) * eff_width();
      return n;
   endfunction

   task automatic run_frames(input logic [sgm_pkg::CSR_DATA_BITS-1:0] w,
                             input logic [sgm_pkg::CSR_DATA_BITS-1:0] h, input int frames);
      set_geometry(w, h);
      push_random(pixels_to_frame_end() + (frames - 1) * eff_width() * eff_height());
      settle();
   endtask

   initial begin
      foreach (upper_mem[i]) begin
         upper_mem[i]  = '0;
         middle_mem[i] = '0;
      end
      foreach (win_cols[i]) win_cols[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: start row 0, then shrink mid-row so the row closes early
      push_pixel(8'h00); push_pixel(8'hFF); push_pixel(8'hA5);
      settle();
      set_geometry(11'd3, 11'd3);
      push_pixel(8'h5A);
      push_pixel(8'hFF); push_pixel(8'h00); push_pixel(8'hFF);
      push_pixel(8'h00); push_pixel(8'hFF); push_pixel(8'h00);
      settle();
      // sizes below the minimum act as 3x3; strongest edge the window can see
      set_geometry(11'd0, 11'd2);
      push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'hFF);
      push_pixel(8'h00); push_pixel(8'h00); push_pixel(8'hFF);
      push_pixel(8'h00); push_pixel(8'hFF); push_pixel(8'hFF);
      settle();

      run_frames(11'd5, 11'd4, 2);
      run_frames(11'd8, 11'd6, 1);
      run_frames(11'd3, 11'd12, 1);
      run_frames(11'd12, 11'd3, 1);
      run_frames(11'd1, 11'd7, 2);

      // narrower rows and a shorter frame from the middle of a frame
      set_geometry(11'd20, 11'd10);
      push_random(20 * 4 + 7);
      settle();
      set_geometry(11'd6, 11'd8);
      push_random(pixels_to_frame_end());
      settle();

      // height cut below the current row: frame closes at this row's end
      set_geometry(11'd10, 11'd12);
      push_random(10 * 6 + 3);
      settle();
      write_csr(sgm_pkg::CSR_FRAME_HEIGHT, 11'd4);
      push_random(pixels_to_frame_end());
      settle();

      no_idle = 1'b1;
      run_frames(11'd16, 11'd8, 1);
      no_idle = 1'b0;

      // oversize width acts as the line store depth; row cut short mid-row
      set_geometry(11'd2047, 11'd3);
      push_random(40);
      settle();
      set_geometry(11'd7, 11'd4);
      push_random(pixels_to_frame_end());
      settle();

      // oversize height acts as 1024; cut back to four rows past row four
      set_geometry(11'd3, 11'd2047);
      push_random(30);
      settle();
      write_csr(sgm_pkg::CSR_FRAME_HEIGHT, 11'd4);
      push_random(pixels_to_frame_end());
      settle();

      run_frames(11'd7, 11'd5, 1);

      $display("Streamed %0d pixels over %0d geometries", pixels_sent, geometries_run);
      $display("%0d gradients checked, %0d frames closed, %0d mismatches",
               gradients_checked, frames_closed, mismatch_count);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timeout with %0d pixels pending, %0d gradients awaited",
               outstanding_pixels, gradient_q.size());
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
